FILE: design/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Operation and status codes shared by the ring buffer deque design.
// ----------------------------------------------------------------------------
`default_nettype none

package rbd_pkg;

  typedef enum logic [2:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_POP_BACK   = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_READ       = 3'd4,
    KIND_CLEAR      = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_UNDERFLOW = 2'd2,
    STATUS_RANGE     = 2'd3
  } status_t;

endpackage

`default_nettype wire

FILE: design/ring_buffer_deque.sv
// A request accepted at a clock edge passes the request register, the middle
// stage and the output register; done is high with its result.
// Throughput: one request per cycle; busy stays low, the ring store has one
// write and one registered read port and front/back words live in registers.
// Reset (rst, synchronous) empties the deque; the ring store keeps its contents.
// ----------------------------------------------------------------------------
// ring_buffer_deque
// Double-ended queue in a circular store with head/tail pointers and count.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_buffer_deque #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  wire  [2:0]         kind,
  input  wire  signed [31:0] write_value,
  input  wire  [3:0]         read_index,
  output logic               done,
  output logic signed [31:0] read_value,
  output logic signed [31:0] front_value,
  output logic signed [31:0] back_value,
  output logic [4:0]         entry_count,
  output logic               is_empty,
  output logic [1:0]         status
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [PW:0]   WRAP     = (PW + 1)'(DEPTH);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? LAST_PTR : p - 1'b1;
  endfunction

  // request register
  logic                  req_valid;
  rbd_pkg::kind_t        req_kind;
  logic [DATA_WIDTH-1:0] req_wval;
  logic [3:0]            req_idx;

  // deque state
  logic [PW-1:0]         head_ptr, head_ptr_next;
  logic [PW-1:0]         tail_ptr, tail_ptr_next;
  logic [CW-1:0]         word_count, word_count_next;
  logic [DATA_WIDTH-1:0] front_word, front_word_next;
  logic [DATA_WIDTH-1:0] back_word, back_word_next;
  logic                  front_pend, front_pend_next;
  logic                  back_pend, back_pend_next;

  // ring store
  logic [DATA_WIDTH-1:0] ring_store [DEPTH];
  logic [DATA_WIDTH-1:0] rd_word;
  logic                  wr_en, rd_en;
  logic [PW-1:0]         wr_addr, rd_addr;

  // middle stage
  logic                  b_valid;
  rbd_pkg::status_t      b_status, status_next;
  logic                  b_read_ok, read_ok_next;

  logic [DATA_WIDTH-1:0] front_eff, back_eff;
  logic [PW-1:0]         head_dec, tail_dec;
  logic [PW:0]           idx_sum, idx_wrapped;

  assign busy = 1'b0;

  // a pop leaves the new end word in the read register until the end word register takes it
  assign front_eff = front_pend ? rd_word : front_word;
  assign back_eff  = back_pend ? rd_word : back_word;

  assign head_dec    = ptr_dec(head_ptr);
  assign tail_dec    = ptr_dec(tail_ptr);
  assign idx_sum     = {1'b0, head_ptr} + (PW + 1)'(req_idx);
  assign idx_wrapped = (idx_sum >= WRAP) ? idx_sum - WRAP : idx_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
    if (start && !busy) begin
      req_kind <= rbd_pkg::kind_t'(kind);
      req_wval <= DATA_WIDTH'($unsigned(write_value));
      req_idx  <= read_index;
    end
  end

  always_comb begin
    head_ptr_next   = head_ptr;
    tail_ptr_next   = tail_ptr;
    word_count_next = word_count;
    front_word_next = front_eff;
    back_word_next  = back_eff;
    front_pend_next = 1'b0;
    back_pend_next  = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = tail_ptr;
    rd_en           = 1'b0;
    rd_addr         = PW'(idx_wrapped);
    status_next     = rbd_pkg::STATUS_OK;
    read_ok_next    = 1'b0;
    if (req_valid) begin
      unique case (req_kind)
        rbd_pkg::KIND_PUSH_BACK: begin
          if (word_count == FULL_CNT) begin
            status_next = rbd_pkg::STATUS_FULL;
          end else begin
            wr_en           = 1'b1;
            wr_addr         = tail_ptr;
            tail_ptr_next   = ptr_inc(tail_ptr);
            word_count_next = word_count + 1'b1;
            back_word_next  = req_wval;
            if (word_count == '0) begin
              front_word_next = req_wval;
            end
          end
        end
        rbd_pkg::KIND_PUSH_FRONT: begin
          if (word_count == FULL_CNT) begin
            status_next = rbd_pkg::STATUS_FULL;
          end else begin
            wr_en           = 1'b1;
            wr_addr         = head_dec;
            head_ptr_next   = head_dec;
            word_count_next = word_count + 1'b1;
            front_word_next = req_wval;
            if (word_count == '0) begin
              back_word_next = req_wval;
            end
          end
        end
        rbd_pkg::KIND_POP_BACK: begin
          if (word_count == '0) begin
            status_next = rbd_pkg::STATUS_UNDERFLOW;
          end else begin
            tail_ptr_next   = tail_dec;
            word_count_next = word_count - 1'b1;
            rd_en           = 1'b1;
            rd_addr         = ptr_dec(tail_dec);
            back_pend_next  = 1'b1;
          end
        end
        rbd_pkg::KIND_POP_FRONT: begin
          if (word_count == '0) begin
            status_next = rbd_pkg::STATUS_UNDERFLOW;
          end else begin
            head_ptr_next   = ptr_inc(head_ptr);
            word_count_next = word_count - 1'b1;
            rd_en           = 1'b1;
            rd_addr         = ptr_inc(head_ptr);
            front_pend_next = 1'b1;
          end
        end
        rbd_pkg::KIND_READ: begin
          if (CMPW'(req_idx) >= CMPW'(word_count)) begin
            status_next = rbd_pkg::STATUS_RANGE;
          end else begin
            rd_en        = 1'b1;
            rd_addr      = PW'(idx_wrapped);
            read_ok_next = 1'b1;
          end
        end
        rbd_pkg::KIND_CLEAR: begin
          head_ptr_next   = '0;
          tail_ptr_next   = '0;
          word_count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_store[wr_addr] <= req_wval;
    end
    if (rd_en) begin
      rd_word <= ring_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr   <= '0;
      tail_ptr   <= '0;
      word_count <= '0;
      front_pend <= 1'b0;
      back_pend  <= 1'b0;
      b_valid    <= 1'b0;
      done       <= 1'b0;
    end else begin
      head_ptr   <= head_ptr_next;
      tail_ptr   <= tail_ptr_next;
      word_count <= word_count_next;
      front_pend <= front_pend_next;
      back_pend  <= back_pend_next;
      b_valid    <= req_valid;
      done       <= b_valid;
    end
    front_word <= front_word_next;
    back_word  <= back_word_next;
    b_status   <= status_next;
    b_read_ok  <= read_ok_next;
  end

  // state seen here is the state right after the request in the middle stage
  always_ff @(posedge clk) begin
    read_value  <= b_read_ok ? 32'(rd_word) : '0;
    front_value <= (word_count != '0) ? 32'(front_eff) : '0;
    back_value  <= (word_count != '0) ? 32'(back_eff) : '0;
    entry_count <= 5'(word_count);
    is_empty    <= (word_count == '0);
    status      <= b_status;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    word_count <= FULL_CNT)
    else $error("word count above depth");

  a_ptr_span: assert property (@(posedge clk) disable iff (rst)
    ((PW + 1)'(tail_ptr) == (PW + 1)'(head_ptr) + (PW + 1)'(word_count)) ||
    ((PW + 1)'(tail_ptr) + WRAP == (PW + 1)'(head_ptr) + (PW + 1)'(word_count)))
    else $error("head, tail and count disagree");

  a_one_pend: assert property (@(posedge clk) disable iff (rst)
    !(front_pend && back_pend))
    else $error("front and back both wait on the read register");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("request without result three cycles later");
`endif

endmodule

`default_nettype wire

FILE: tb/ring_buffer_deque_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_buffer_deque_tb
// Self-checking bench for the ring buffer deque. A scoreboard keeps its own
// copy of the ring store, pointers and count, predicts the response to every
// accepted request and compares each done-strobed response field by field.
// ----------------------------------------------------------------------------

module ring_buffer_deque_tb;

  localparam int          QUEUE_DEPTH   = 16;
  localparam int          STALL_LIMIT   = 1000;
  localparam int          DRAIN_CYCLES  = 8;
  localparam int          RANDOM_ITEMS  = 1750;
  localparam logic [2:0]  KIND_SPARE_6  = 3'd6;
  localparam logic [2:0]  KIND_SPARE_7  = 3'd7;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED,
    MIX_READS,
    MIX_NOISE
  } mix_t;

  typedef struct packed {
    logic [31:0]      read_word;
    logic [31:0]      front_word;
    logic [31:0]      back_word;
    logic [4:0]       count;
    logic             empty;
    rbd_pkg::status_t code;
  } deque_response_t;

  class deque_scoreboard;
    logic [31:0]     ring [QUEUE_DEPTH];
    bit [3:0]        head;
    bit [3:0]        tail;
    bit [4:0]        count;
    deque_response_t pending [$];
    int              errors;

    function void note_request(logic [2:0] op, logic [31:0] word, logic [3:0] idx);
      deque_response_t r;
      bit [3:0]        pos;
      bit [3:0]        last;
      r = '0;
      r.code = rbd_pkg::STATUS_OK;
      case (op)
        rbd_pkg::KIND_PUSH_BACK: begin
          if (count == QUEUE_DEPTH) begin
            r.code = rbd_pkg::STATUS_FULL;
          end else begin
            ring[tail] = word;
            tail = tail + 4'd1;
            count = count + 5'd1;
          end
        end
        rbd_pkg::KIND_PUSH_FRONT: begin
          if (count == QUEUE_DEPTH) begin
            r.code = rbd_pkg::STATUS_FULL;
          end else begin
            head = head - 4'd1;
            ring[head] = word;
            count = count + 5'd1;
          end
        end
        rbd_pkg::KIND_POP_BACK: begin
          if (count == 0) begin
            r.code = rbd_pkg::STATUS_UNDERFLOW;
          end else begin
            tail = tail - 4'd1;
            count = count - 5'd1;
          end
        end
        rbd_pkg::KIND_POP_FRONT: begin
          if (count == 0) begin
            r.code = rbd_pkg::STATUS_UNDERFLOW;
          end else begin
            head = head + 4'd1;
            count = count - 5'd1;
          end
        end
        rbd_pkg::KIND_READ: begin
          if ({1'b0, idx} >= count) begin
            r.code = rbd_pkg::STATUS_RANGE;
          end else begin
            pos = head + idx;
            r.read_word = ring[pos];
          end
        end
        rbd_pkg::KIND_CLEAR: begin
          head = '0;
          tail = '0;
          count = '0;
        end
        default: begin
        end
      endcase
      if (count != 0) begin
        last = tail - 4'd1;
        r.front_word = ring[head];
        r.back_word = ring[last];
      end
      r.count = count;
      r.empty = (count == 0);
      pending.insert(pending.size(), r);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_response(logic [31:0] rd, logic [31:0] fr, logic [31:0] bk,
                        logic [4:0] cnt, logic empty, logic [1:0] code);
      deque_response_t e;
      if (pending.size() == 0) begin
        report_mismatch("response with no request outstanding");
        return;
      end
      e = pending[0];
      pending.delete(0);
      if (rd !== e.read_word)
        report_mismatch($sformatf("read_value exp %h got %h", e.read_word, rd));
      if (fr !== e.front_word)
        report_mismatch($sformatf("front_value exp %h got %h", e.front_word, fr));
      if (bk !== e.back_word)
        report_mismatch($sformatf("back_value exp %h got %h", e.back_word, bk));
      if (cnt !== e.count)
        report_mismatch($sformatf("entry_count exp %0d got %0d", e.count, cnt));
      if (empty !== e.empty)
        report_mismatch($sformatf("is_empty exp %b got %b", e.empty, empty));
      if (code !== e.code)
        report_mismatch($sformatf("status exp %0d got %0d", e.code, code));
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         kind;
  logic signed [31:0] write_value;
  logic [3:0]         read_index;
  logic               done;
  logic signed [31:0] read_value;
  logic signed [31:0] front_value;
  logic signed [31:0] back_value;
  logic [4:0]         entry_count;
  logic               is_empty;
  logic [1:0]         status;

  deque_scoreboard sb;
  int              stall_count;
  int              burst_left;

  ring_buffer_deque i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .write_value (write_value),
    .read_index  (read_index),
    .done        (done),
    .read_value  (read_value),
    .front_value (front_value),
    .back_value  (back_value),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .status      (status)
  );

  always #5 clk = ~clk;

  // monitor and watchdog: sample at the edge, before any driven update lands
  always @(posedge clk) begin
    if (!rst) begin
      if (start && busy === 1'b0)
        sb.note_request(kind, write_value, read_index);
      if (done === 1'b1)
        sb.check_response(read_value, front_value, back_value, entry_count,
                          is_empty, status);
    end
    if ((start && busy === 1'b0) || done === 1'b1) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  task automatic send_request(logic [2:0] op, logic [31:0] word, logic [3:0] idx);
    start       <= 1'b1;
    kind        <= op;
    write_value <= word;
    read_index  <= idx;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // bursts of random length, random gaps, and now and then a long gapless run
  task automatic issue(logic [2:0] op, logic [31:0] word, logic [3:0] idx);
    send_request(op, word, idx);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(0, 20);
      hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
    end
  endtask

  task automatic wait_for_idle();
    hold_off(1);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [3:0] pick_index();
    if ($urandom_range(0, 1) == 0 || sb.count == 0)
      return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, sb.count - 1));
  endfunction

  function automatic logic [2:0] pick_kind(mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (roll < 45)      return rbd_pkg::KIND_PUSH_BACK;
        else if (roll < 85) return rbd_pkg::KIND_PUSH_FRONT;
        else if (roll < 95) return rbd_pkg::KIND_READ;
        else                return rbd_pkg::KIND_POP_FRONT;
      end
      MIX_DRAIN: begin
        if (roll < 40)      return rbd_pkg::KIND_POP_BACK;
        else if (roll < 80) return rbd_pkg::KIND_POP_FRONT;
        else if (roll < 95) return rbd_pkg::KIND_READ;
        else                return rbd_pkg::KIND_PUSH_BACK;
      end
      MIX_BALANCED: begin
        if (roll < 2)       return rbd_pkg::KIND_CLEAR;
        else if (roll < 22) return rbd_pkg::KIND_PUSH_BACK;
        else if (roll < 42) return rbd_pkg::KIND_PUSH_FRONT;
        else if (roll < 60) return rbd_pkg::KIND_POP_BACK;
        else if (roll < 78) return rbd_pkg::KIND_POP_FRONT;
        else                return rbd_pkg::KIND_READ;
      end
      MIX_READS: begin
        if (roll < 70)      return rbd_pkg::KIND_READ;
        else if (roll < 85) return rbd_pkg::KIND_PUSH_BACK;
        else                return rbd_pkg::KIND_PUSH_FRONT;
      end
      default: return 3'($urandom_range(0, 7));
    endcase
  endfunction

  initial begin
    mix_t       mix;
    logic [2:0] op;
    int         run_len;
    int         counted;
    bit         paused;

    sb          = new();
    clk         = 1'b0;
    rst         = 1'b1;
    start       = 1'b0;
    kind        = rbd_pkg::KIND_PUSH_BACK;
    write_value = '0;
    read_index  = '0;
    stall_count = 0;
    burst_left  = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty-queue corner cases, extremes, spare kinds, wrap on push front
    issue(rbd_pkg::KIND_CLEAR,      32'h0,         4'd0);
    issue(rbd_pkg::KIND_POP_BACK,   32'h0,         4'd0);
    issue(rbd_pkg::KIND_POP_FRONT,  32'h0,         4'd0);
    issue(rbd_pkg::KIND_READ,       32'h0,         4'd0);
    issue(rbd_pkg::KIND_READ,       32'h0,         4'd15);
    issue(rbd_pkg::KIND_PUSH_FRONT, 32'h7fff_ffff, 4'd0);
    issue(rbd_pkg::KIND_READ,       32'h0,         4'd0);
    issue(rbd_pkg::KIND_PUSH_BACK,  32'h8000_0000, 4'd0);
    issue(rbd_pkg::KIND_PUSH_FRONT, 32'hffff_ffff, 4'd15);
    issue(rbd_pkg::KIND_PUSH_BACK,  32'h0000_0000, 4'd15);
    issue(rbd_pkg::KIND_READ,       32'hffff_ffff, 4'd0);
    issue(rbd_pkg::KIND_READ,       32'h0,         4'd1);
    issue(rbd_pkg::KIND_READ,       32'h0,         4'd3);
    issue(rbd_pkg::KIND_READ,       32'h0,         4'd4);
    issue(KIND_SPARE_6,             32'h1234_5678, 4'd2);
    issue(KIND_SPARE_7,             32'h8765_4321, 4'd1);
    issue(rbd_pkg::KIND_POP_BACK,   32'h0,         4'd0);
    issue(rbd_pkg::KIND_POP_FRONT,  32'h0,         4'd0);
    issue(rbd_pkg::KIND_POP_BACK,   32'h0,         4'd0);
    issue(rbd_pkg::KIND_POP_FRONT,  32'h0,         4'd0);
    issue(rbd_pkg::KIND_POP_BACK,   32'h0,         4'd0);
    issue(rbd_pkg::KIND_PUSH_BACK,  32'h5a5a_a5a5, 4'd0);
    issue(rbd_pkg::KIND_CLEAR,      32'h0,         4'd0);
    wait_for_idle();

    // random: episodes of one operation mix, the first one uses the fill mix
    counted = 0;
    paused  = 1'b0;
    mix     = MIX_FILL;
    while (counted < RANDOM_ITEMS) begin
      run_len = $urandom_range(8, 40);
      repeat (run_len) begin
        op = pick_kind(mix);
        issue(op, pick_word(), pick_index());
        if (op != KIND_SPARE_6 && op != KIND_SPARE_7)
          counted++;
      end
      if (!paused && counted >= RANDOM_ITEMS / 2) begin
        wait_for_idle();
        paused = 1'b1;
      end
      mix = mix_t'($urandom_range(0, 4));
    end

    wait_for_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report_mismatch($sformatf("%0d responses never arrived", sb.pending.size()));
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: ring_buffer_deque.f
design/rbd_pkg.sv
design/ring_buffer_deque.sv
tb/ring_buffer_deque_tb.sv
